// ===== rtl/core/salc_pkg.sv =====
// Package for the set-associative LRU cache: constants and sequencer states.
package salc_pkg;
    localparam int WAYS_DEF        = 2;
    localparam int SETS_DEF        = 64;
    localparam int BLOCK_BYTES_DEF = 64;
    localparam int MEM_BYTES_DEF   = 65536;
    localparam int MAX_ACCESS      = 8;
    localparam int ADDR_W          = 16;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_WB,
        ST_FILL,
        ST_FILL_WR,
        ST_ACC,
        ST_ACC_WR,
        ST_DONE
    } state_t;
endpackage

// ===== rtl/core/set_assoc_lru_cache.sv =====
// Top level of the set-associative LRU cache with its backing byte memory.
//
// Input channel in_valid/in_ready carries one access item (command, address,
// size_bytes, store_data). Output channel out_valid/out_ready returns one
// result item per access (hit, load_data, wrote_back, bad_access).
// write_back_mode is to be written by the user through cfg_we/cfg_wdata only
// while no item is in flight; the block does not enforce it. One sequencer
// moves the bytes one at a time through each memory. A rejected access goes
// straight to its result. A hit looks up the ways in order up to the matching
// one, then moves the size_bytes bytes of the access; a write-through store
// miss looks up all WAYS ways and then writes its bytes to memory. An
// allocating miss adds a fill of the whole block, and before it a write-back
// of the victim when it is dirty. The next item is accepted only once the
// result is taken. After reset the block clears the backing memory one byte
// a cycle with in_ready low; valid and dirty bits reset at once and the LRU
// ranks are set during the same pass. The result stays in its register until
// taken; while the receiver stalls, no new item is accepted.
module set_assoc_lru_cache #(
    parameter int WAYS        = salc_pkg::WAYS_DEF,
    parameter int SETS        = salc_pkg::SETS_DEF,
    parameter int BLOCK_BYTES = salc_pkg::BLOCK_BYTES_DEF,
    parameter int MEM_BYTES   = salc_pkg::MEM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [15:0] address,
    input  logic [3:0]  size_bytes,
    input  logic [63:0] store_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [63:0] load_data,
    output logic        wrote_back,
    output logic        bad_access
);
    localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SW  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int OW  = $clog2(BLOCK_BYTES);
    localparam int MW  = $clog2(MEM_BYTES);
    localparam int LW  = (SETS * WAYS * BLOCK_BYTES > 1) ?
                         $clog2(SETS * WAYS * BLOCK_BYTES) : 1;
    localparam int TW  = salc_pkg::ADDR_W - OW - ((SETS > 1) ? SW : 0) > 0 ?
                         salc_pkg::ADDR_W - OW - ((SETS > 1) ? SW : 0) : 1;
    localparam int NL  = SETS * WAYS;

    salc_pkg::state_t state_reg, state_next;

    logic              mode_reg;
    logic              cmd_reg;
    logic [15:0]       addr_reg;
    logic [3:0]        size_reg;
    logic [63:0]       sdata_reg;
    logic [63:0]       ldata_reg;
    logic              hit_reg, wb_reg, bad_reg;
    logic [WW-1:0]     way_reg;
    logic [MW:0]       cnt_reg;
    logic [WW-1:0]     look_reg;
    logic              found_reg;

    logic [NL-1:0]     valid_reg, dirty_reg;

    // Per-set rows of tags and LRU ranks, one row read a cycle
    logic [WAYS*TW-1:0] tag_rows [SETS];
    logic [WAYS*WW-1:0] rank_rows [SETS];
    logic [WAYS*TW-1:0] tag_rd, tag_wd;
    logic [WAYS*WW-1:0] rank_rd, rank_wd, rank_upd, rank_init;
    logic               tag_we, rank_we;
    logic [SW-1:0]      meta_ra, rank_wa, in_set;
    logic [WW-1:0]      used_way;

    logic [7:0]        line_mem [SETS * WAYS * BLOCK_BYTES];
    logic [7:0]        mem [MEM_BYTES];
    logic [7:0]        line_rd, mem_rd;

    // Address fields
    logic [OW-1:0]     offs;
    logic [SW-1:0]     set_idx;
    logic [TW-1:0]     tag_val;
    logic [OW:0]       end_off;
    logic [16:0]       end_addr;
    logic              bad_now;
    always_comb
    begin
        offs    = addr_reg[OW-1:0];
        set_idx = (SETS > 1) ? SW'(addr_reg >> OW) : '0;
        tag_val = TW'(addr_reg >> (OW + ((SETS > 1) ? SW : 0)));
        end_off = {1'b0, offs} + (OW+1)'(size_reg);
        end_addr = {1'b0, addr_reg} + 17'(size_reg);
        bad_now = (size_reg == 4'd0) || (size_reg > 4'(salc_pkg::MAX_ACCESS)) ||
                  (end_off > (OW+1)'(BLOCK_BYTES)) || (end_addr > 17'(MEM_BYTES));
    end

    // Line index of the way under test and the chosen way
    logic [$clog2(NL+1)-1:0] look_line, way_line;
    assign look_line = ($clog2(NL+1))'(set_idx) * ($clog2(NL+1))'(WAYS)
                       + ($clog2(NL+1))'(look_reg);
    assign way_line  = ($clog2(NL+1))'(set_idx) * ($clog2(NL+1))'(WAYS)
                       + ($clog2(NL+1))'(way_reg);

    logic [WW-1:0] look_i;
    logic [$clog2(NL > 1 ? NL : 2)-1:0] li, wi;
    assign li = look_line[$clog2(NL > 1 ? NL : 2)-1:0];
    assign wi = way_line[$clog2(NL > 1 ? NL : 2)-1:0];
    assign look_i = look_reg;

    // Byte counter selects: byte index within access or block
    logic [OW-1:0] blk_byte;
    logic [2:0]    acc_byte;
    assign blk_byte = cnt_reg[OW-1:0];
    assign acc_byte = cnt_reg[2:0];

    logic [OW-1:0] acc_off;
    assign acc_off = offs + OW'(acc_byte);

    logic [LW-1:0] line_base;
    assign line_base = LW'(wi) << OW;

    // Victim block address from its old tag
    logic [TW-1:0] vic_tag;
    logic [MW-1:0] victim_blk;
    logic [MW-1:0] victim_base, blk_base;
    assign vic_tag     = tag_rd[TW*way_reg +: TW];
    assign victim_blk  = MW'(vic_tag) * MW'(SETS) + MW'(set_idx);
    assign victim_base = victim_blk << OW;
    assign blk_base    = MW'(addr_reg >> OW) << OW;

    logic fill_last;
    assign fill_last = (state_reg == salc_pkg::ST_FILL_WR) &&
                       (cnt_reg == (MW+1)'(BLOCK_BYTES - 1));

    // Memory addresses driven by the sequencer
    logic [LW-1:0] line_ra;
    logic [MW-1:0] mem_ra;
    always_comb
    begin
        line_ra = line_base | LW'(blk_byte);
        mem_ra  = blk_base | MW'(blk_byte);
        if (state_reg == salc_pkg::ST_ACC)
        begin
            line_ra = line_base | LW'(acc_off);
        end
    end

    // Write controls
    logic          line_we, mem_we;
    logic [LW-1:0] line_wa;
    logic [MW-1:0] mem_wa;
    logic [7:0]    line_wd, mem_wd;
    logic [7:0]    st_byte;
    assign st_byte = sdata_reg[8*acc_byte +: 8];

    always_comb
    begin
        line_we = 1'b0;
        mem_we  = 1'b0;
        line_wa = line_base | LW'(acc_off);
        mem_wa  = MW'(addr_reg) + MW'(acc_byte);
        line_wd = st_byte;
        mem_wd  = st_byte;
        case (state_reg)
            salc_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = cnt_reg[MW-1:0];
                mem_wd = 8'd0;
            end
            salc_pkg::ST_WB:
            begin
                // line_rd holds byte cnt-1 of the victim
                mem_we = (cnt_reg != '0);
                mem_wa = victim_base | MW'(blk_byte - OW'(1));
                mem_wd = line_rd;
            end
            salc_pkg::ST_FILL_WR:
            begin
                line_we = 1'b1;
                line_wa = line_base | LW'(blk_byte);
                line_wd = mem_rd;
            end
            salc_pkg::ST_ACC_WR:
            begin
                if (cmd_reg == salc_pkg::CMD_STORE)
                begin
                    line_we = found_reg || mode_reg;
                    mem_we  = !mode_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_wa] <= line_wd;
        end
        line_rd <= line_mem[line_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_rd <= mem[mem_ra];
    end

    // Rank row that reset leaves in every set
    always_comb
    begin
        rank_init = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            rank_init[WW*w +: WW] = WW'(WAYS - 1 - w);
        end
    end

    // Make the used way most recent; lower ranks move up by one
    always_comb
    begin
        used_way = (state_reg == salc_pkg::ST_LOOK) ? look_reg : way_reg;
        rank_upd = rank_rd;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WW'(w) != used_way &&
                rank_rd[WW*w +: WW] < rank_rd[WW*used_way +: WW])
            begin
                rank_upd[WW*w +: WW] = rank_rd[WW*w +: WW] + WW'(1);
            end
        end
        rank_upd[WW*used_way +: WW] = '0;
    end

    // Row read address: the incoming item's set while idle
    assign in_set  = (SETS > 1) ? SW'(address >> OW) : '0;
    assign meta_ra = (state_reg == salc_pkg::ST_IDLE) ? in_set : set_idx;

    // Tag and rank row writes
    always_comb
    begin
        rank_we = 1'b0;
        rank_wa = set_idx;
        rank_wd = rank_upd;
        tag_we  = 1'b0;
        tag_wd  = tag_rd;
        tag_wd[TW*way_reg +: TW] = tag_val;
        case (state_reg)
            salc_pkg::ST_CLEAR:
            begin
                rank_we = (cnt_reg < (MW+1)'(SETS));
                rank_wa = SW'(cnt_reg);
                rank_wd = rank_init;
            end
            salc_pkg::ST_LOOK:
            begin
                rank_we = !bad_now && look_match;
            end
            salc_pkg::ST_FILL_WR:
            begin
                rank_we = fill_last;
                tag_we  = fill_last;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_rows[rank_wa] <= rank_wd;
        end
        if (tag_we)
        begin
            tag_rows[set_idx] <= tag_wd;
        end
        rank_rd <= rank_rows[meta_ra];
        tag_rd  <= tag_rows[meta_ra];
    end

    // Victim choice: way holding the highest rank, else way 0
    logic [WW-1:0] victim;
    always_comb
    begin
        victim = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (rank_rd[WW*w +: WW] == WW'(WAYS - 1))
            begin
                victim = WW'(w);
            end
        end
    end

    logic last_look;
    assign last_look = (look_reg == WW'(WAYS - 1));
    logic look_match;
    assign look_match = valid_reg[li] && (tag_rd[TW*look_reg +: TW] == tag_val);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            salc_pkg::ST_CLEAR:
                if (cnt_reg == (MW+1)'(MEM_BYTES - 1)) state_next = salc_pkg::ST_IDLE;
            salc_pkg::ST_IDLE:
                if (in_valid) state_next = salc_pkg::ST_LOOK;
            salc_pkg::ST_LOOK:
                if (bad_now) state_next = salc_pkg::ST_DONE;
                else if (look_match) state_next = salc_pkg::ST_ACC;
                else if (last_look)
                begin
                    if (cmd_reg == salc_pkg::CMD_STORE && !mode_reg)
                        state_next = salc_pkg::ST_ACC;
                    else if (valid_reg[SW'(set_idx) * WAYS + victim] &&
                             dirty_reg[SW'(set_idx) * WAYS + victim])
                        state_next = salc_pkg::ST_WB;
                    else
                        state_next = salc_pkg::ST_FILL;
                end
            salc_pkg::ST_WB:
                if (cnt_reg == (MW+1)'(BLOCK_BYTES)) state_next = salc_pkg::ST_FILL;
            salc_pkg::ST_FILL:
                state_next = salc_pkg::ST_FILL_WR;
            salc_pkg::ST_FILL_WR:
                if (cnt_reg == (MW+1)'(BLOCK_BYTES - 1)) state_next = salc_pkg::ST_ACC;
                else state_next = salc_pkg::ST_FILL;
            salc_pkg::ST_ACC:
                state_next = salc_pkg::ST_ACC_WR;
            salc_pkg::ST_ACC_WR:
                if (cnt_reg == (MW+1)'(size_reg - 4'd1)) state_next = salc_pkg::ST_DONE;
                else state_next = salc_pkg::ST_ACC;
            salc_pkg::ST_DONE:
                if (out_ready) state_next = salc_pkg::ST_IDLE;
            default:
                state_next = salc_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready   = (state_reg == salc_pkg::ST_IDLE);
        out_valid  = (state_reg == salc_pkg::ST_DONE);
        hit        = hit_reg;
        load_data  = ldata_reg;
        wrote_back = wb_reg;
        bad_access = bad_reg;
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= salc_pkg::ST_CLEAR;
            mode_reg  <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= '0;
            dirty_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            case (state_reg)
                salc_pkg::ST_CLEAR:
                    cnt_reg <= cnt_reg + 1'b1;
                salc_pkg::ST_IDLE:
                begin
                    cnt_reg  <= '0;
                    look_reg <= '0;
                    if (in_valid)
                    begin
                        cmd_reg   <= command;
                        addr_reg  <= address;
                        size_reg  <= size_bytes;
                        sdata_reg <= store_data;
                        ldata_reg <= '0;
                        hit_reg   <= 1'b0;
                        wb_reg    <= 1'b0;
                        bad_reg   <= 1'b0;
                        found_reg <= 1'b0;
                    end
                end
                salc_pkg::ST_LOOK:
                begin
                    if (bad_now)
                        bad_reg <= 1'b1;
                    else if (look_match)
                    begin
                        hit_reg   <= 1'b1;
                        found_reg <= 1'b1;
                        way_reg   <= look_i;
                        if (cmd_reg == salc_pkg::CMD_STORE && mode_reg)
                            dirty_reg[li] <= 1'b1;
                    end
                    else if (last_look)
                    begin
                        way_reg <= victim;
                        if (!(cmd_reg == salc_pkg::CMD_STORE && !mode_reg))
                        begin
                            if (valid_reg[SW'(set_idx) * WAYS + victim] &&
                                dirty_reg[SW'(set_idx) * WAYS + victim])
                                wb_reg <= 1'b1;
                        end
                    end
                    else
                        look_reg <= look_reg + 1'b1;
                end
                salc_pkg::ST_WB:
                    cnt_reg <= (cnt_reg == (MW+1)'(BLOCK_BYTES)) ? '0 : cnt_reg + 1'b1;
                salc_pkg::ST_FILL_WR:
                begin
                    if (cnt_reg == (MW+1)'(BLOCK_BYTES - 1))
                    begin
                        cnt_reg <= '0;
                        found_reg <= 1'b1;
                        valid_reg[wi] <= 1'b1;
                        dirty_reg[wi] <= (cmd_reg == salc_pkg::CMD_STORE);
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                salc_pkg::ST_ACC_WR:
                begin
                    if (cmd_reg == salc_pkg::CMD_LOAD)
                        ldata_reg[8*acc_byte +: 8] <= line_rd;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the set-associative LRU cache.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_WAYS     = salc_pkg::WAYS_DEF;
    localparam int N_SETS     = salc_pkg::SETS_DEF;
    localparam int BLK        = salc_pkg::BLOCK_BYTES_DEF;
    localparam int BACKING_BYTES = salc_pkg::MEM_BYTES_DEF;
    localparam int CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        logic        hit;
        logic [63:0] load_data;
        logic        wrote_back;
        logic        bad_access;
    } cache_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [15:0] address;
    logic [3:0]  size_bytes;
    logic [63:0] store_data;
    logic        out_valid;
    logic        out_ready;
    logic        hit;
    logic [63:0] load_data;
    logic        wrote_back;
    logic        bad_access;

    // Shadow copy of the cache and its memory
    logic [7:0]  shadow_mem [BACKING_BYTES];
    logic        shadow_valid [N_SETS][N_WAYS];
    logic        shadow_dirty [N_SETS][N_WAYS];
    int unsigned shadow_tag [N_SETS][N_WAYS];
    int unsigned shadow_rank [N_SETS][N_WAYS];
    logic [7:0]  shadow_line [N_SETS][N_WAYS][BLK];
    logic        shadow_wb_mode;

    cache_result_t pending_results[$];
    int          mismatch_count = 0;
    longint      cycle_count = 0;
    bit          no_idle;

    set_assoc_lru_cache dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .address(address), .size_bytes(size_bytes), .store_data(store_data),
        .out_valid(out_valid), .out_ready(out_ready), .hit(hit),
        .load_data(load_data), .wrote_back(wrote_back), .bad_access(bad_access)
    );

    // Toggle the clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Clear the shadow state as reset does
    function automatic void shadow_reset();
        for (int a = 0; a < BACKING_BYTES; a++) shadow_mem[a] = 8'h00;
        for (int s = 0; s < N_SETS; s++)
            for (int w = 0; w < N_WAYS; w++)
            begin
                shadow_valid[s][w] = 1'b0;
                shadow_dirty[s][w] = 1'b0;
                shadow_tag[s][w] = 0;
                shadow_rank[s][w] = N_WAYS - 1 - w;
                for (int b = 0; b < BLK; b++) shadow_line[s][w][b] = 8'h00;
            end
        shadow_wb_mode = 1'b0;
    endfunction

    // Promote a way to most recent
    function automatic void touch_way(int unsigned s, int unsigned way);
        int unsigned old_rank;
        old_rank = shadow_rank[s][way];
        for (int w = 0; w < N_WAYS; w++)
            if (w != way && shadow_rank[s][w] < old_rank) shadow_rank[s][w]++;
        shadow_rank[s][way] = 0;
    endfunction

    // Evict the least recent way, write it back if dirty, refill it
    function automatic int unsigned refill_way(int unsigned s, int unsigned tg,
                                               int unsigned blk_num, ref logic wb);
        int unsigned way;
        int unsigned base;
        way = 0;
        for (int w = N_WAYS - 1; w >= 0; w--)
            if (shadow_rank[s][w] == N_WAYS - 1) way = w;
        if (shadow_valid[s][way] && shadow_dirty[s][way])
        begin
            base = (shadow_tag[s][way] * N_SETS + s) * BLK;
            if (base + BLK <= BACKING_BYTES)
                for (int b = 0; b < BLK; b++) shadow_mem[base + b] = shadow_line[s][way][b];
            wb = 1'b1;
        end
        base = blk_num * BLK;
        for (int b = 0; b < BLK; b++) shadow_line[s][way][b] = shadow_mem[base + b];
        shadow_valid[s][way] = 1'b1;
        shadow_dirty[s][way] = 1'b0;
        shadow_tag[s][way] = tg;
        touch_way(s, way);
        return way;
    endfunction

    // Work out the result of one access and update the shadow state
    function automatic cache_result_t predict_access(logic cmd, logic [15:0] addr,
                                                     logic [3:0] sz, logic [63:0] data);
        cache_result_t r;
        int unsigned blk_num, offs, s, tg, way;
        logic found;
        logic wb;
        r = '0;
        wb = 1'b0;
        found = 1'b0;
        way = 0;
        blk_num = addr / BLK;
        offs = addr % BLK;
        if (sz == 0 || sz > salc_pkg::MAX_ACCESS || offs + sz > BLK ||
            addr + sz > BACKING_BYTES)
        begin
            r.bad_access = 1'b1;
            return r;
        end
        s = blk_num % N_SETS;
        tg = blk_num / N_SETS;
        for (int w = N_WAYS - 1; w >= 0; w--)
            if (shadow_valid[s][w] && shadow_tag[s][w] == tg)
            begin
                found = 1'b1;
                way = w;
            end
        if (cmd == salc_pkg::CMD_LOAD)
        begin
            if (found) touch_way(s, way);
            else way = refill_way(s, tg, blk_num, wb);
            for (int i = 0; i < sz; i++)
                r.load_data[8*i +: 8] = shadow_line[s][way][offs + i];
        end
        else if (!shadow_wb_mode)
        begin
            for (int i = 0; i < sz; i++)
            begin
                shadow_mem[addr + i] = data[8*i +: 8];
                if (found) shadow_line[s][way][offs + i] = data[8*i +: 8];
            end
            if (found) touch_way(s, way);
        end
        else
        begin
            if (found) touch_way(s, way);
            else way = refill_way(s, tg, blk_num, wb);
            for (int i = 0; i < sz; i++) shadow_line[s][way][offs + i] = data[8*i +: 8];
            shadow_dirty[s][way] = 1'b1;
        end
        r.hit = found;
        r.wrote_back = wb;
        return r;
    endfunction

    // Send one access item, idling at random before it
    task automatic send_access(logic cmd, logic [15:0] addr, logic [3:0] sz,
                               logic [63:0] data);
        while (!no_idle && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        address <= addr;
        size_bytes <= sz;
        store_data <= data;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results.push_back(predict_access(cmd, addr, sz, data));
        @(negedge clk);
    endtask

    // Wait until every expected result has come, then let the block settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // Write the mode register while idle
    task automatic set_mode(logic mode);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow_wb_mode = mode;
    endtask

    // Random access, mostly in bounds inside a few hot sets; one in ten has random address and size
    task automatic send_random_access();
        logic [15:0] addr;
        logic [3:0]  sz;
        sz = 4'($urandom_range(8, 1));
        if ($urandom_range(9) == 0)
        begin
            addr = 16'($urandom);
            sz = 4'($urandom);
        end
        else
        begin
            addr = {4'($urandom_range(15)), 2'($urandom_range(3)), 4'($urandom_range(3)),
                    6'($urandom_range(64 - sz))};
        end
        send_access(1'($urandom_range(1)), addr, sz, {$urandom, $urandom});
    endtask

    // Edges of the fields and the rejected accesses
    task automatic test_directed();
        send_access(salc_pkg::CMD_LOAD, 16'h0000, 4'd1, '0);
        send_access(salc_pkg::CMD_STORE, 16'h0000, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(salc_pkg::CMD_LOAD, 16'h0000, 4'd8, '0);
        send_access(salc_pkg::CMD_STORE, 16'hFFF8, 4'd8, 64'hA5A5_5A5A_0123_4567);
        send_access(salc_pkg::CMD_LOAD, 16'hFFF8, 4'd8, '0);
        send_access(salc_pkg::CMD_LOAD, 16'hFFFF, 4'd1, '0);
        send_access(salc_pkg::CMD_LOAD, 16'h0010, 4'd0, '0);
        send_access(salc_pkg::CMD_STORE, 16'h0010, 4'd9, '1);
        send_access(salc_pkg::CMD_LOAD, 16'h0010, 4'd15, '0);
        send_access(salc_pkg::CMD_LOAD, 16'h003C, 4'd5, '0);
        send_access(salc_pkg::CMD_STORE, 16'hFFFC, 4'd8, '1);
        send_access(salc_pkg::CMD_LOAD, 16'h0038, 4'd8, '0);
    endtask

    // Conflicting blocks in one set force evictions, and write-backs in write-back mode
    task automatic test_evictions(logic mode);
        set_mode(mode);
        for (int t = 0; t < 4; t++)
        begin
            send_access(salc_pkg::CMD_STORE, {4'(t), 6'd5, 6'd8}, 4'd8,
                        {$urandom, $urandom});
            send_access(salc_pkg::CMD_LOAD, {4'(t), 6'd5, 6'd8}, 4'd8, '0);
        end
        send_access(salc_pkg::CMD_LOAD, {4'd0, 6'd5, 6'd8}, 4'd8, '0);
    endtask

    // Random traffic, the mode picked at random at intervals, with a stretch free of idles and stalls
    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 120 == 0) set_mode(1'($urandom_range(1)));
            no_idle = (n >= 200 && n < 260);
            send_random_access();
        end
        no_idle = 1'b0;
    endtask

    // Check each result item against the oldest expectation
    always @(posedge clk)
    begin
        cache_result_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("result item with none expected");
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.hit !== hit || want.load_data !== load_data ||
                    want.wrote_back !== wrote_back || want.bad_access !== bad_access)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("exp hit=%b data=%h wb=%b bad=%b got %b %h %b %b",
                                 want.hit, want.load_data, want.wrote_back,
                                 want.bad_access, hit, load_data, wrote_back, bad_access);
                end
            end
        end
    end

    // Stall the receiver at random
    always @(negedge clk)
        out_ready <= no_idle || ($urandom_range(99) >= 15);

    // End the run on a stuck block
    always @(posedge clk)
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        in_valid = 1'b0;
        command = salc_pkg::CMD_LOAD;
        address = '0;
        size_bytes = 4'd1;
        store_data = '0;
        no_idle = 1'b0;
        shadow_reset();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_evictions(1'b1);
        test_evictions(1'b0);
        test_random(500);
        set_mode(1'b1);
        set_mode(1'b0);
        drain_results();
        repeat (200) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
